// ===== rtl/assert_macros.svh =====
// assertion macros included by the keyframe update gate
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define KFUG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kfug assertion failed");

// condition that must never hold outside reset
`define KFUG_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kfug forbidden condition");

`else

`define KFUG_ASSERT(label, prop)
`define KFUG_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== rtl/kfug_pkg.sv =====
// types, constants and register codes of the keyframe update gate
`default_nettype none

package kfug_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DIST_THR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_THR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIME_THR  = 2'd2;

  // reset values of the thresholds
  localparam logic [31:0] DistThrReset  = 32'd1000;
  localparam logic [31:0] AngleThrReset = 32'd8192;
  localparam logic [31:0] TimeThrReset  = 32'd5000000;

  // sequencer step counts: radix-4 square-sum, then one root bit per step
  localparam int unsigned MulSteps  = 16;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned CntW      = 5;

  localparam logic signed [47:0] TimeMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] TimeMin = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DONE
  } kfug_state_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic        [47:0] time_us;
  } kfug_in_t;

  typedef struct packed {
    logic               update_needed;
    logic        [31:0] interval_distance;
    logic        [31:0] interval_angle;
    logic signed [47:0] interval_time;
  } kfug_out_t;

endpackage

`default_nettype wire

// ===== rtl/kfug_chan_if.sv =====
// valid/ready channel carrying one word of a given payload type
`default_nettype none

interface kfug_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/keyframe_update_gate.sv =====
// keyframe update gate: travel, turning and time based keyframe trigger
`default_nettype none

// Each accepted odometry word yields exactly one result word. The block works
// on one word at a time and takes no new word until it is back in idle. It
// latches the word together with |dx|, |dy|, the wrapped heading change and
// the elapsed time, then runs a radix-4 shift-add unit that builds
// dx^2 + dy^2 two multiplier bits per cycle, then a restoring square root that
// settles one root bit per cycle, and last folds the step into the saturating
// sums and loads the output register. The output register frees the datapath,
// so a result may wait at the output while the next word is taken; only a
// result that is still waiting when the following one is ready holds the
// block. Threshold writes are meant for idle periods only.

module keyframe_update_gate (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [kfug_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [kfug_pkg::CfgDataW-1:0] cfg_data_i,
  kfug_chan_if.sink                         in_i,
  kfug_chan_if.source                       out_o
);
  import kfug_pkg::*;

  `include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  kfug_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // thresholds
  logic [31:0] dist_thr_q, angle_thr_q, time_thr_q;

  // gate state carried from word to word
  logic signed [31:0] prev_x_q, prev_y_q;
  logic        [15:0] prev_hd_q;
  logic        [31:0] sum_dist_q, sum_angle_q;
  logic        [47:0] last_t_q;
  logic               seen_q;

  // per-word working registers
  logic [31:0]        mcx_q, mcy_q;     // multiplicands |dx|, |dy|
  logic [31:0]        mlx_q, mly_q;     // multiplier shift registers, msb digit first
  logic [64:0]        acc_q;            // square sum, then radicand shift register
  logic [33:0]        rem_q;            // partial remainder of the root
  logic [31:0]        root_q;
  logic [16:0]        ang_q;            // magnitude of the wrapped heading change
  logic signed [47:0] itime_q;          // clamped elapsed time
  logic               tge_q;            // elapsed time reached its threshold
  logic               neg_q;            // elapsed time negative
  logic               first_q;          // word is the first one seen
  logic [47:0]        t_q;              // word timestamp, latched on intake

  // output register
  logic      out_valid_q;
  kfug_out_t out_q;

  // handshakes
  logic in_fire, done_fire;

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == CntW'(MulSteps - 1)) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    done_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_DONE: done_fire  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // word intake: deltas, heading change, elapsed time
  // ---------------------------------------------------------------------------
  logic [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [15:0] dh;
  logic [16:0] dh_mag;
  logic [48:0] elapsed;
  logic signed [47:0] itime;
  logic        tge;

  always_comb begin
    dx = {in_i.data.pos_x[31], in_i.data.pos_x} - {prev_x_q[31], prev_x_q};
    dy = {in_i.data.pos_y[31], in_i.data.pos_y} - {prev_y_q[31], prev_y_q};
    adx = dx[32] ? (~dx + 33'd1) : dx;
    ady = dy[32] ? (~dy + 33'd1) : dy;
    // a half turn counts as 32768 either way
    dh     = in_i.data.heading - prev_hd_q;
    dh_mag = dh[15] ? (17'h10000 - {1'b0, dh}) : {1'b0, dh};
    // exact 49-bit signed difference of two 48-bit timestamps
    elapsed = seen_q ? ({1'b0, in_i.data.time_us} - {1'b0, last_t_q}) : '0;
    tge     = $signed(elapsed) >= $signed({17'b0, time_thr_q});
    if (elapsed[48] != elapsed[47]) begin
      itime = elapsed[48] ? TimeMin : TimeMax;
    end else begin
      itime = $signed(elapsed[47:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // square-sum step: acc = 4*acc + mcx*digit_x + mcy*digit_y
  // ---------------------------------------------------------------------------
  logic [33:0] term_x, term_y;
  logic [64:0] acc_mul;

  always_comb begin
    term_x  = ({2'b0, mcx_q} & {34{mlx_q[30]}}) + ({1'b0, mcx_q, 1'b0} & {34{mlx_q[31]}});
    term_y  = ({2'b0, mcy_q} & {34{mly_q[30]}}) + ({1'b0, mcy_q, 1'b0} & {34{mly_q[31]}});
    acc_mul = {acc_q[62:0], 2'b00} + {31'b0, term_x} + {31'b0, term_y};
  end

  // ---------------------------------------------------------------------------
  // root step: bring down two radicand bits, try root*4+1
  // ---------------------------------------------------------------------------
  logic [35:0] rem_try, root_try;
  logic        root_bit;

  always_comb begin
    rem_try  = {rem_q, acc_q[63:62]};
    root_try = {2'b0, root_q, 2'b01};
    root_bit = rem_try >= root_try;
  end

  // ---------------------------------------------------------------------------
  // finish: saturating sums and the update decision
  // ---------------------------------------------------------------------------
  logic [32:0] step_dist;
  logic [33:0] dist_wide;
  logic [32:0] angle_wide;
  logic [31:0] sum_dist_new, sum_angle_new;
  logic        update;

  always_comb begin
    // a square sum past 64 bits stands for a step of 2^32, which saturates
    step_dist     = acc_q[64] ? {1'b1, 32'b0} : {1'b0, root_q};
    dist_wide     = {2'b0, sum_dist_q} + {1'b0, step_dist};
    angle_wide    = {1'b0, sum_angle_q} + {16'b0, ang_q};
    sum_dist_new  = (dist_wide[33:32] != 2'b00) ? '1 : dist_wide[31:0];
    sum_angle_new = angle_wide[32] ? '1 : angle_wide[31:0];
    update = (sum_dist_new >= dist_thr_q || sum_angle_new >= angle_thr_q ||
              tge_q || first_q) && !neg_q;
  end

  // ---------------------------------------------------------------------------
  // control and gate state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dist_thr_q  <= DistThrReset;
      angle_thr_q <= AngleThrReset;
      time_thr_q  <= TimeThrReset;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_hd_q   <= '0;
      sum_dist_q  <= '0;
      sum_angle_q <= '0;
      last_t_q    <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIST_THR:  dist_thr_q  <= cfg_data_i;
          CFG_ANGLE_THR: angle_thr_q <= cfg_data_i;
          CFG_TIME_THR:  time_thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // previous pose follows every word
      if (in_fire) begin
        prev_x_q  <= in_i.data.pos_x;
        prev_y_q  <= in_i.data.pos_y;
        prev_hd_q <= in_i.data.heading;
      end
      if (done_fire) begin
        if (update) begin
          sum_dist_q  <= '0;
          sum_angle_q <= '0;
          last_t_q    <= t_q;
          seen_q      <= 1'b1;
        end else begin
          sum_dist_q  <= sum_dist_new;
          sum_angle_q <= sum_angle_new;
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      // first word counts as standing still
      mcx_q   <= seen_q ? adx[31:0] : '0;
      mcy_q   <= seen_q ? ady[31:0] : '0;
      mlx_q   <= seen_q ? adx[31:0] : '0;
      mly_q   <= seen_q ? ady[31:0] : '0;
      acc_q   <= '0;
      ang_q   <= seen_q ? dh_mag : '0;
      itime_q <= itime;
      tge_q   <= tge;
      neg_q   <= elapsed[48];
      first_q <= !seen_q;
      t_q     <= in_i.data.time_us;
    end
    if (state_q == ST_MUL) begin
      acc_q <= acc_mul;
      mlx_q <= {mlx_q[29:0], 2'b00};
      mly_q <= {mly_q[29:0], 2'b00};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == ST_SQRT) begin
      // bit 64 holds the overflow flag through the root iteration
      acc_q  <= {acc_q[64], acc_q[61:0], 2'b00};
      rem_q  <= root_bit ? 34'(rem_try - root_try) : rem_try[33:0];
      root_q <= {root_q[30:0], root_bit};
    end
    if (done_fire) begin
      out_q.update_needed     <= update;
      out_q.interval_distance <= sum_dist_new;
      out_q.interval_angle    <= sum_angle_new;
      out_q.interval_time     <= itime_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `KFUG_ASSERT(a_fire_starts_mul, in_fire |=> (state_q == ST_MUL))
  `KFUG_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `KFUG_ASSERT_NEVER(a_update_on_negative_time,
                     out_o.valid && out_o.data.update_needed && out_o.data.interval_time[47])

endmodule

`default_nettype wire

// ===== dv/keyframe_update_checker.sv =====
`timescale 1ns / 1ps
// keyframe update gate checker: predicts every result word and compares it
module keyframe_update_checker
  import kfug_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  kfug_in_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  kfug_out_t           out_word_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  updates_o
);

  localparam logic signed [48:0] ElapsedHi = 49'sd140737488355327;
  localparam logic signed [48:0] ElapsedLo = -49'sd140737488355328;
  localparam int unsigned        ShownMax  = 10;

  // mirrored thresholds
  logic [31:0]        dist_thr;
  logic [31:0]        ang_thr;
  logic [31:0]        time_thr;

  // predicted gate state
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic [15:0]        last_h;
  logic [31:0]        acc_dist;
  logic [31:0]        acc_ang;
  logic [47:0]        keyframe_time;
  logic               anchored;

  kfug_out_t          due_q[$];
  int                 bad;
  int                 seen;
  int                 raised;

  function automatic logic [31:0] floor_root(input logic [63:0] n);
    logic [31:0] root;
    logic [31:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (32'd1 << b);
      if ({32'd0, cand} * {32'd0, cand} <= n) root = cand;
    end
    return root;
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic predict_gate(input kfug_in_t w, output kfug_out_t r);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [63:0]        ax;
    logic [63:0]        ay;
    logic [64:0]        sq_sum;
    logic [32:0]        step_dist;
    logic [32:0]        step_ang;
    logic [15:0]        dh;
    logic signed [48:0] el;
    logic               fire;
    step_dist = '0;
    step_ang  = '0;
    el        = '0;
    if (anchored) begin
      dx = {w.pos_x[31], w.pos_x} - {last_x[31], last_x};
      dy = {w.pos_y[31], w.pos_y} - {last_y[31], last_y};
      ax = {31'd0, (dx[32] ? -dx : dx)};
      ay = {31'd0, (dy[32] ? -dy : dy)};
      sq_sum = {1'b0, ax * ax} + {1'b0, ay * ay};
      // a square sum past 64 bits counts as a step of 2^32
      step_dist = sq_sum[64] ? 33'h1_0000_0000 : {1'b0, floor_root(sq_sum[63:0])};
      dh = w.heading - last_h;
      step_ang = dh[15] ? (33'h1_0000 - {17'd0, dh}) : {17'd0, dh};
      el = $signed({1'b0, w.time_us}) - $signed({1'b0, keyframe_time});
    end
    last_x = w.pos_x;
    last_y = w.pos_y;
    last_h = w.heading;
    acc_dist = sat_sum(acc_dist, step_dist);
    acc_ang  = sat_sum(acc_ang, step_ang);
    fire = (acc_dist >= dist_thr || acc_ang >= ang_thr ||
            el >= $signed({17'd0, time_thr}) || !anchored) && !el[48];
    r.update_needed     = fire;
    r.interval_distance = acc_dist;
    r.interval_angle    = acc_ang;
    if (el > ElapsedHi)      r.interval_time = ElapsedHi[47:0];
    else if (el < ElapsedLo) r.interval_time = ElapsedLo[47:0];
    else                     r.interval_time = el[47:0];
    if (fire) begin
      acc_dist      = '0;
      acc_ang       = '0;
      keyframe_time = w.time_us;
      anchored      = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kfug_out_t want;
    kfug_out_t nxt;
    if (!rst_ni) begin
      dist_thr      = DistThrReset;
      ang_thr       = AngleThrReset;
      time_thr      = TimeThrReset;
      last_x        = '0;
      last_y        = '0;
      last_h        = '0;
      acc_dist      = '0;
      acc_ang       = '0;
      keyframe_time = '0;
      anchored      = 1'b0;
      due_q.delete();
      bad    = 0;
      seen   = 0;
      raised = 0;
    end else begin
      // a result word always belongs to a word taken at an earlier edge
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          bad++;
          if (bad <= ShownMax)
            $display("[%0t] unexpected result word: upd %0b dist %0d ang %0d time %0d",
                     $realtime, out_word_i.update_needed, out_word_i.interval_distance,
                     out_word_i.interval_angle, out_word_i.interval_time);
        end else begin
          want = due_q.pop_front();
          seen++;
          if (out_word_i.update_needed) raised++;
          if (out_word_i.update_needed !== want.update_needed ||
              out_word_i.interval_distance !== want.interval_distance ||
              out_word_i.interval_angle !== want.interval_angle ||
              out_word_i.interval_time !== want.interval_time) begin
            bad++;
            if (bad <= ShownMax)
              $display("[%0t] result word %0d: expected upd %0b dist %0d ang %0d time %0d, got upd %0b dist %0d ang %0d time %0d",
                       $realtime, seen, want.update_needed, want.interval_distance,
                       want.interval_angle, want.interval_time,
                       out_word_i.update_needed, out_word_i.interval_distance,
                       out_word_i.interval_angle, out_word_i.interval_time);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIST_THR:  dist_thr = cfg_data_i;
          CFG_ANGLE_THR: ang_thr  = cfg_data_i;
          CFG_TIME_THR:  time_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_gate(in_word_i, nxt);
        due_q.push_back(nxt);
      end
    end
    mismatches_o <= bad;
    pending_o    <= due_q.size();
    checked_o    <= seen;
    updates_o    <= raised;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// keyframe update gate testbench top: reset, threshold programming, odometry stimulus, verdict
module testbench;
  import kfug_pkg::*;

  localparam int unsigned        CycleLimit  = 2000000;
  localparam int unsigned        SettleTicks = 60;     // a bit more than one word of latency
  localparam logic [CfgIdxW-1:0] CFG_SPARE   = 2'd3;   // index the block must ignore
  localparam logic [47:0]        TimeTop     = 48'hFFFF_FFFF_FFFF;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = CFG_DIST_THR;
  logic [CfgDataW-1:0] cfg_data = '0;

  // tb side of the channels, known from time zero
  logic                src_valid = 1'b0;
  kfug_in_t            src_word  = '0;
  logic                snk_ready = 1'b0;

  kfug_chan_if #(.payload_t(kfug_in_t))  odo_ch ();
  kfug_chan_if #(.payload_t(kfug_out_t)) gate_ch ();

  assign odo_ch.valid  = src_valid;
  assign odo_ch.data   = src_word;
  assign gate_ch.ready = snk_ready;

  int          mismatches;
  int          pending;
  int          checked;
  int          updates;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  int          settings   = 0;
  int          words_sent = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;

  // random walk of the robot pose, carried across phases
  logic [31:0] walk_x;
  logic [31:0] walk_y;
  logic [15:0] walk_h;
  logic [47:0] walk_t;

  always #1 clk_i = ~clk_i;

  keyframe_update_gate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (odo_ch),
    .out_o      (gate_ch)
  );

  keyframe_update_checker u_gate_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (odo_ch.valid),
    .in_ready_i   (odo_ch.ready),
    .in_word_i    (odo_ch.data),
    .out_valid_i  (gate_ch.valid),
    .out_ready_i  (gate_ch.ready),
    .out_word_i   (gate_ch.data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .updates_o    (updates)
  );

  // result sink: short random stalls, now and then a rare long one that outlasts
  // a whole word of processing so the output register backs up
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      snk_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (snk_idle_en && $urandom_range(1999) < 1) begin
      snk_ready  <= 1'b0;
      stall_left <= $urandom_range(120, 60);
    end else begin
      snk_ready <= !(snk_idle_en && $urandom_range(99) < 10);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d result words still due", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic kfug_in_t odo_word(input logic [31:0] x, input logic [31:0] y,
                                        input logic [15:0] h, input logic [47:0] t);
    kfug_in_t w;
    w.pos_x   = x;
    w.pos_y   = y;
    w.heading = h;
    w.time_us = t;
    return w;
  endfunction

  // offer one odometry word, optionally after a random gap, and wait for it to be taken
  task automatic send_word(input kfug_in_t w);
    int gap;
    gap = (src_idle_en && $urandom_range(99) < 15) ? $urandom_range(60, 1) : 0;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_word  <= w;
    @(posedge clk_i);
    while (!odo_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // hold the sender until every predicted result word has come back
  task automatic drain_results();
    src_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // write all thresholds back to back, plus a junk write to the unused index
  task automatic program_thresholds(input logic [31:0] d, input logic [31:0] a,
                                    input logic [31:0] t);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DIST_THR;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_idx  <= CFG_ANGLE_THR;
    cfg_data <= a;
    @(posedge clk_i);
    cfg_idx  <= CFG_TIME_THR;
    cfg_data <= t;
    @(posedge clk_i);
    cfg_idx  <= CFG_SPARE;
    cfg_data <= $urandom;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  // mostly a plausible trajectory; some teleports, parked samples,
  // clock steps backwards and long silences mixed in
  task automatic run_random(input int n, input bit pause_mid);
    int          kind;
    logic [31:0] stride;
    logic [47:0] back;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain_results();
      kind = $urandom_range(99);
      if (kind < 65) begin
        stride = $urandom_range(32'd1 << $urandom_range(12));
        walk_x = $urandom_range(1) ? walk_x + stride : walk_x - stride;
        stride = $urandom_range(32'd1 << $urandom_range(12));
        walk_y = $urandom_range(1) ? walk_y + stride : walk_y - stride;
        walk_h = walk_h + 16'($urandom_range(3000)) - 16'd1500;
        walk_t = walk_t + 48'($urandom_range(300000));
      end else if (kind < 77) begin
        walk_x = $urandom;
        walk_y = $urandom;
        walk_h = 16'($urandom);
        walk_t = walk_t + 48'($urandom_range(10000000));
      end else if (kind < 87) begin
        walk_t = walk_t + 48'($urandom_range(2000));
      end else if (kind < 95) begin
        back = 48'($urandom_range(3000000, 1));
        if (walk_t > back) walk_t = walk_t - back;
      end else begin
        walk_t = walk_t + {16'd0, $urandom};
      end
      send_word(odo_word(walk_x, walk_y, walk_h, walk_t));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: first word always opens a keyframe
    send_word(odo_word(32'd0, 32'd0, 16'd0, 48'd100));
    // 3-4-5 step, well under the travel threshold
    send_word(odo_word(32'd3, 32'd4, 16'd0, 48'd200));
    // out to the most negative corner with a half turn
    send_word(odo_word(32'h8000_0000, 32'h8000_0000, 16'd32768, 48'd300));
    // square sum past 64 bits, distance sum clamps
    send_word(odo_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 48'd400));
    // heading wraps forward through zero
    send_word(odo_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 48'd500));
    // wraps back, and the clock is behind the last keyframe
    send_word(odo_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 48'd350));

    // tight thresholds so each trigger can be hit exactly
    drain_results();
    program_thresholds(32'd5, 32'd100, 32'd1000);
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'hFFFF, 48'd600)); // travel == threshold
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd98, 48'd700));   // turning one short
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd99, 48'd800));   // turning == threshold
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd99, 48'd1800));  // elapsed == threshold
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd99, 48'd2799));  // elapsed one short

    // zero thresholds fire on anything except a negative elapsed time
    drain_results();
    program_thresholds(32'd0, 32'd0, 32'd0);
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd99, 48'd2799));
    send_word(odo_word(32'h7FFF_FFFC, 32'h7FFF_FFFB, 16'd99, 48'd2000));

    walk_x = 32'h7FFF_FFFC;
    walk_y = 32'h7FFF_FFFB;
    walk_h = 16'd99;
    walk_t = 48'd2799;

    // random phases, one threshold setting each
    drain_results();
    program_thresholds(DistThrReset, AngleThrReset, TimeThrReset);
    run_random(250, 1'b0);

    drain_results();
    program_thresholds($urandom_range(100000), $urandom_range(40000),
                       $urandom_range(20000000));
    run_random(250, 1'b1);

    // all-ones thresholds, no idling on either side for the whole phase
    drain_results();
    src_idle_en <= 1'b0;
    snk_idle_en <= 1'b0;
    program_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(250, 1'b0);
    drain_results();
    src_idle_en <= 1'b1;
    snk_idle_en <= 1'b1;

    program_thresholds(32'd0, 32'd0, 32'd0);
    run_random(200, 1'b0);

    drain_results();
    program_thresholds($urandom, $urandom, $urandom);
    run_random(250, 1'b0);

    // closing words drive the timestamp to its ends; the latest time locks
    // out later keyframes, so these come last
    drain_results();
    program_thresholds(DistThrReset, AngleThrReset, TimeThrReset);
    send_word(odo_word(walk_x, walk_y, walk_h, TimeTop));        // elapsed past signed max
    send_word(odo_word(walk_x, walk_y, walk_h, 48'd0));          // elapsed past signed min
    send_word(odo_word(walk_x, walk_y, walk_h + 16'd1, TimeTop)); // elapsed back to zero

    drain_results();
    repeat (SettleTicks) @(posedge clk_i);

    $display("sent %0d odometry words under %0d threshold settings", words_sent, settings);
    $display("checked %0d result words, %0d of them raised a keyframe", checked, updates);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d result words missing", mismatches, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kfug_pkg.sv
rtl/kfug_chan_if.sv
rtl/keyframe_update_gate.sv
dv/keyframe_update_checker.sv
dv/testbench.sv
